### sv/mfhp_pkg.sv
package mfhp_pkg;

   typedef enum logic [3:0] {
      PH_FC_LO = 4'd0,
      PH_FC_HI = 4'd1,
      PH_SEQ   = 4'd2,
      PH_DPAN  = 4'd3,
      PH_DADDR = 4'd4,
      PH_SPAN  = 4'd5,
      PH_SADDR = 4'd6,
      PH_SCF   = 4'd7,
      PH_CNT   = 4'd8,
      PH_KEY   = 4'd9,
      PH_BODY  = 4'd10,
      PH_SKIP  = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_TYPE    = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_BAD_COMB    = 3'd3,
      ST_BAD_ADDR    = 3'd4,
      ST_BAD_SEC     = 3'd5,
      ST_NO_MIC      = 3'd6,
      ST_MALFORMED   = 3'd7
   } status_type;

   localparam logic [2:0] FT_DATA          = 3'd1;
   localparam logic [2:0] FT_ACK           = 3'd2;
   localparam logic [1:0] FV_2015          = 2'd2;
   localparam logic [1:0] AM_NONE          = 2'd0;
   localparam logic [1:0] AM_SHORT         = 2'd2;
   localparam logic [1:0] AM_EXT           = 2'd3;
   localparam logic [2:0] SEC_ENC_MIC_64   = 3'd6;
   localparam logic [1:0] KEY_MODE_INDEX   = 2'd1;
   localparam int         RULE_COUNT       = 18;
   localparam int         MIC_BYTES        = 8;

   // Each rule: bits 4:0 are the lookup key (compression in bit 4, src mode in 3:2, dst mode in 1:0),
   // bit 5 marks a destination PAN ID and bit 6 a source PAN ID.
   typedef logic [6:0] rule_type;

   localparam rule_type PAN_RULES [RULE_COUNT] = '{
      7'b0000000, 7'b0110000, 7'b0100010,
      7'b0100011, 7'b0010010, 7'b0010011,
      7'b1001000, 7'b1001100, 7'b0011000,
      7'b0011100, 7'b0101111, 7'b0011111,
      7'b1101010, 7'b1101110, 7'b1101011,
      7'b0111110, 7'b0111011, 7'b0111010
   };

   typedef struct packed {
      logic       hit;
      logic [1:0] presence;
   } rule_hit_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic       confirm_mode;
   } word_type;

   typedef struct packed {
      status_type  status;
      logic        ack_request;
      logic        seq_present;
      logic [7:0]  seq_number;
      logic [1:0]  dst_mode;
      logic [1:0]  src_mode;
      logic [15:0] dst_pan;
      logic [63:0] dst_address;
      logic [15:0] src_pan;
      logic [63:0] src_address;
      logic [31:0] sec_counter;
      logic [7:0]  key_index;
   } rsp_type;

   function automatic rule_hit_type pan_rule_lookup(input logic [4:0] key);
      rule_hit_type res;
      res = '0;
      for (int i = 0; i < RULE_COUNT; i++) begin
         if (PAN_RULES[i][4:0] == key) begin
            res.hit      = 1'b1;
            res.presence = PAN_RULES[i][6:5];
         end
      end
      return res;
   endfunction

   function automatic logic field_present(input phase_type ph, input logic [15:0] fc,
                                          input logic [1:0] pp);
      logic res;
      case (ph)
         PH_SEQ:   res = ~fc[8];
         PH_DPAN:  res = pp[0];
         PH_DADDR: res = (fc[11:10] == AM_EXT);
         PH_SPAN:  res = pp[1];
         PH_SADDR: res = (fc[15:14] == AM_EXT);
         PH_SCF, PH_CNT, PH_KEY: res = fc[3];
         default:  res = 1'b1;
      endcase
      return res;
   endfunction

   function automatic phase_type next_phase(input phase_type ph, input logic [15:0] fc,
                                            input logic [1:0] pp);
      logic [3:0] base;
      logic [3:0] cand;
      logic       found;
      phase_type  res;
      base  = ph;
      found = 1'b0;
      res   = PH_BODY;
      for (int unsigned i = 1; i <= 9; i++) begin
         cand = base + 4'(i);
         if (!found && (cand >= 4'(PH_BODY) || field_present(phase_type'(cand), fc, pp))) begin
            found = 1'b1;
            res   = (cand >= 4'(PH_BODY)) ? PH_BODY : phase_type'(cand);
         end
      end
      return res;
   endfunction

endpackage

### sv/mac_frame_header_parser_core.sv
// A final word waits in the input register until the result register is free; its result
// is then registered and shown on rsp_. Throughput: one word per cycle unless a final
// word waits; the registers are the only stages, with combinational parsing between.
// Reset is synchronous and active high: it empties both registers, returns the parser to
// the start of a frame with all collected fields cleared, and sets own_pan_id to zero.
module mac_frame_header_parser_core #(
   parameter int MAX_FRAME_BYTES = 2047
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic        req_confirm_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_ack_request,
   output logic        rsp_seq_present,
   output logic [7:0]  rsp_seq_number,
   output logic [1:0]  rsp_dst_mode,
   output logic [1:0]  rsp_src_mode,
   output logic [15:0] rsp_dst_pan,
   output logic [63:0] rsp_dst_address,
   output logic [15:0] rsp_src_pan,
   output logic [63:0] rsp_src_address,
   output logic [31:0] rsp_sec_counter,
   output logic [7:0]  rsp_key_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_own_pan_id
);

   mfhp_pkg::word_type word_ff;
   mfhp_pkg::rsp_type  rsp_ff;
   mfhp_pkg::rsp_type  rsp_next;
   logic        word_valid_ff;
   logic        rsp_valid_ff;
   logic [15:0] own_pan_ff;
   logic        rsp_free;
   logic        step;
   logic        accept;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = word_valid_ff && (!word_ff.last_byte || rsp_free);
   assign req_stall = word_valid_ff && !step;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_pan_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_pan_ff <= csr_own_pan_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else if (accept) begin
         word_valid_ff <= 1'b1;
      end else if (step) begin
         word_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= '{frame_byte: req_frame_byte, last_byte: req_last_byte,
                      confirm_mode: req_confirm_mode};
      end
   end

   mfhp_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .word       (word_ff),
      .own_pan_id (own_pan_ff),
      .rsp_next   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && word_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && word_ff.last_byte) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_status        = rsp_ff.status;
   assign rsp_ack_request   = rsp_ff.ack_request;
   assign rsp_seq_present   = rsp_ff.seq_present;
   assign rsp_seq_number    = rsp_ff.seq_number;
   assign rsp_dst_mode      = rsp_ff.dst_mode;
   assign rsp_src_mode      = rsp_ff.src_mode;
   assign rsp_dst_pan       = rsp_ff.dst_pan;
   assign rsp_dst_address   = rsp_ff.dst_address;
   assign rsp_src_pan       = rsp_ff.src_pan;
   assign rsp_src_address   = rsp_ff.src_address;
   assign rsp_sec_counter   = rsp_ff.sec_counter;
   assign rsp_key_index     = rsp_ff.key_index;

endmodule

### sv/mfhp_parser.sv
module mfhp_parser #(
   parameter int MAX_FRAME_BYTES = 2047
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  mfhp_pkg::word_type word,
   input  logic [15:0]       own_pan_id,
   output mfhp_pkg::rsp_type rsp_next
);

   localparam int TW = $clog2(MAX_FRAME_BYTES + 1);

   mfhp_pkg::phase_type  phase_ff, phase_in;
   mfhp_pkg::status_type err_ff, err_in;
   mfhp_pkg::rule_hit_type rule;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] fc_ff, fc_in;
   logic        mode_ff, mode_in;
   logic [1:0]  pp_ff, pp_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] dpan_ff, dpan_in;
   logic [63:0] daddr_ff, daddr_in;
   logic [15:0] span_ff, span_in;
   logic [63:0] saddr_ff, saddr_in;
   logic [31:0] ctr_ff, ctr_in;
   logic [7:0]  key_ff, key_in;
   logic [TW-1:0] trail_ff, trail_in;
   logic [2:0]  last_idx;
   logic [7:0]  b;

   assign b = word.frame_byte;

   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      fc_in    = fc_ff;
      mode_in  = mode_ff;
      pp_in    = pp_ff;
      seq_in   = seq_ff;
      dpan_in  = dpan_ff;
      daddr_in = daddr_ff;
      span_in  = span_ff;
      saddr_in = saddr_ff;
      ctr_in   = ctr_ff;
      key_in   = key_ff;
      trail_in = trail_ff;
      rule     = mfhp_pkg::pan_rule_lookup({fc_ff[6], word.frame_byte[7:6],
                                            word.frame_byte[3:2]});
      case (phase_ff)
         mfhp_pkg::PH_DPAN, mfhp_pkg::PH_SPAN: last_idx = 3'd1;
         mfhp_pkg::PH_CNT:                     last_idx = 3'd3;
         default:                              last_idx = 3'd7;
      endcase
      if (step_valid) begin
         case (phase_ff)
            mfhp_pkg::PH_FC_LO: begin
               mode_in  = word.confirm_mode;
               fc_in    = {8'h00, b};
               phase_in = mfhp_pkg::PH_FC_HI;
            end
            mfhp_pkg::PH_FC_HI: begin
               fc_in = {b, fc_ff[7:0]};
               if (!(fc_in[2:0] == mfhp_pkg::FT_DATA ||
                     (mode_ff && fc_in[2:0] == mfhp_pkg::FT_ACK))) begin
                  err_in   = mfhp_pkg::ST_BAD_TYPE;
                  phase_in = mfhp_pkg::PH_SKIP;
               end else if (fc_in[13:12] != mfhp_pkg::FV_2015) begin
                  err_in   = mfhp_pkg::ST_BAD_VERSION;
                  phase_in = mfhp_pkg::PH_SKIP;
               end else if (!rule.hit) begin
                  err_in   = mfhp_pkg::ST_BAD_COMB;
                  phase_in = mfhp_pkg::PH_SKIP;
               end else if (fc_in[11:10] == mfhp_pkg::AM_SHORT ||
                            fc_in[15:14] == mfhp_pkg::AM_SHORT) begin
                  err_in   = mfhp_pkg::ST_BAD_ADDR;
                  phase_in = mfhp_pkg::PH_SKIP;
               end else begin
                  pp_in = rule.presence;
                  if (!rule.presence[0]) begin
                     dpan_in = own_pan_id;
                  end
                  phase_in = mfhp_pkg::next_phase(mfhp_pkg::PH_FC_HI, fc_in, rule.presence);
               end
            end
            mfhp_pkg::PH_SEQ: begin
               seq_in   = b;
               phase_in = mfhp_pkg::next_phase(mfhp_pkg::PH_SEQ, fc_ff, pp_ff);
            end
            mfhp_pkg::PH_DPAN, mfhp_pkg::PH_DADDR, mfhp_pkg::PH_SPAN,
            mfhp_pkg::PH_SADDR, mfhp_pkg::PH_CNT: begin
               case (phase_ff)
                  mfhp_pkg::PH_DPAN:  dpan_in[{cnt_ff[0], 3'b000} +: 8]    = b;
                  mfhp_pkg::PH_DADDR: daddr_in[{cnt_ff, 3'b000} +: 8]      = b;
                  mfhp_pkg::PH_SPAN:  span_in[{cnt_ff[0], 3'b000} +: 8]    = b;
                  mfhp_pkg::PH_SADDR: saddr_in[{cnt_ff, 3'b000} +: 8]      = b;
                  default:            ctr_in[{cnt_ff[1:0], 3'b000} +: 8]   = b;
               endcase
               if (cnt_ff == last_idx) begin
                  cnt_in   = 3'd0;
                  phase_in = mfhp_pkg::next_phase(phase_ff, fc_ff, pp_ff);
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            mfhp_pkg::PH_SCF: begin
               if (b[2:0] != mfhp_pkg::SEC_ENC_MIC_64 ||
                   b[4:3] != mfhp_pkg::KEY_MODE_INDEX || b[5]) begin
                  err_in   = mfhp_pkg::ST_BAD_SEC;
                  phase_in = mfhp_pkg::PH_SKIP;
               end else begin
                  phase_in = mfhp_pkg::PH_CNT;
               end
            end
            mfhp_pkg::PH_KEY: begin
               key_in   = b;
               trail_in = '0;
               phase_in = mfhp_pkg::PH_BODY;
            end
            mfhp_pkg::PH_BODY: begin
               if (trail_ff < TW'(MAX_FRAME_BYTES)) begin
                  trail_in = trail_ff + TW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_next = '0;
      if (err_in != mfhp_pkg::ST_OK) begin
         rsp_next.status = err_in;
      end else if (phase_in != mfhp_pkg::PH_BODY) begin
         rsp_next.status = mfhp_pkg::ST_MALFORMED;
      end else if (fc_in[3] && trail_in < TW'(mfhp_pkg::MIC_BYTES)) begin
         rsp_next.status = mfhp_pkg::ST_NO_MIC;
      end else begin
         rsp_next.status        = mfhp_pkg::ST_OK;
         rsp_next.ack_request   = fc_in[5];
         rsp_next.seq_present   = ~fc_in[8];
         rsp_next.seq_number    = seq_in;
         rsp_next.dst_mode      = fc_in[11:10];
         rsp_next.src_mode      = fc_in[15:14];
         rsp_next.dst_pan       = dpan_in;
         rsp_next.dst_address   = daddr_in;
         rsp_next.src_pan       = pp_in[1] ? span_in : dpan_in;
         rsp_next.src_address   = saddr_in;
         rsp_next.sec_counter   = ctr_in;
         rsp_next.key_index     = key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_valid && word.last_byte)) begin
         phase_ff <= mfhp_pkg::PH_FC_LO;
         err_ff   <= mfhp_pkg::ST_OK;
         cnt_ff   <= '0;
         fc_ff    <= '0;
         mode_ff  <= 1'b0;
         pp_ff    <= '0;
         seq_ff   <= '0;
         dpan_ff  <= '0;
         daddr_ff <= '0;
         span_ff  <= '0;
         saddr_ff <= '0;
         ctr_ff   <= '0;
         key_ff   <= '0;
         trail_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
         fc_ff    <= fc_in;
         mode_ff  <= mode_in;
         pp_ff    <= pp_in;
         seq_ff   <= seq_in;
         dpan_ff  <= dpan_in;
         daddr_ff <= daddr_in;
         span_ff  <= span_in;
         saddr_ff <= saddr_in;
         ctr_ff   <= ctr_in;
         key_ff   <= key_in;
         trail_ff <= trail_in;
      end
   end

endmodule
